>>> rtl/core/sha_pad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 message padder package
// Shared constants and the command/status structs between controller and
// datapath.
// ---------------------------------------------------------------------------
package sha_pad_pkg;

	localparam int unsigned COUNT_W = 61;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned POS_W   = 7;

	localparam logic [7:0]       PAD_MARK     = 8'h80;
	localparam logic [POS_W-1:0] LEN_POS      = 7'd56;
	localparam logic [POS_W-1:0] LEN_POS_NEXT = 7'd120;
	localparam logic [POS_W-1:0] WORD_BYTES   = 7'd4;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// one-hot datapath commands
	typedef struct packed {
		logic append;
		logic first;
		logic zero;
		logic len_hi;
		logic len_lo;
	} pad_cmd_t;

	typedef struct packed {
		logic word_done;
		logic first_last;
		logic pad_last;
	} pad_status_t;

endpackage

>>> rtl/core/sha256_message_padder_top.sv
`timescale 1ns / 1ps
// A word completed by an append transaction appears in the cycle after acceptance.
// Throughput: one append transaction per cycle while the output is not stalled.
// A finish transaction emits 3 to 18 words from the next cycle, one per cycle through
// the single output register while not stalled; input stalls until the last is loaded.
// Reset (arst_n low) clears the byte counter, partial word, state and output valid.
// ---------------------------------------------------------------------------
// SHA-256 message padder
// Packs message bytes into big-endian words and appends SHA-256 padding.
// ---------------------------------------------------------------------------
module sha256_message_padder_top import sha_pad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] word,
	output logic              block_end,
	output logic              message_end
);

	pad_cmd_t    ctl;
	pad_status_t status;

	sha_pad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.status    (status),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	sha_pad_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.data_byte   (data_byte),
		.status      (status),
		.word        (word),
		.block_end   (block_end),
		.message_end (message_end)
	);

	// the length word always closes a block
	a_end_closes_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> block_end)
		else $error("message end without block end");

	// a finish transaction loads its first word at once
	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_FINISH |=> out_valid)
		else $error("finish without output word");

	// padding holds off further input
	a_finish_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_FINISH |=> in_stall)
		else $error("input taken during padding");

endmodule

>>> rtl/core/sha_pad_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 padder datapath
// Byte counter, partial word gather, padding position and output register.
// ---------------------------------------------------------------------------
module sha_pad_datapath import sha_pad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pad_cmd_t          ctl,
	input  logic [7:0]        data_byte,
	output pad_status_t       status,
	output logic [WORD_W-1:0] word,
	output logic              block_end,
	output logic              message_end
);

	logic [COUNT_W-1:0] count_q;
	logic [WORD_W-1:0]  partial_q;
	logic [POS_W-1:0]   pos_q;
	logic               hi_q;
	logic [WORD_W-1:0]  word_q;
	logic               block_end_q;
	logic               message_end_q;

	logic [COUNT_W-1:0] count_inc;
	logic [WORD_W-1:0]  gathered;
	logic [WORD_W-1:0]  first_word;
	logic [POS_W-1:0]   pos_first;
	logic [POS_W-1:0]   pos_pad;
	logic               hi_now;
	logic [POS_W-1:0]   tgt_now;
	logic [POS_W-1:0]   tgt_q;

	always_comb begin
		count_inc = count_q + {{(COUNT_W-1){1'b0}}, 1'b1};
		gathered  = {partial_q[23:0], data_byte};
		hi_now    = (count_q[5:3] == 3'b111);
		tgt_now   = hi_now ? LEN_POS_NEXT : LEN_POS;
		tgt_q     = hi_q ? LEN_POS_NEXT : LEN_POS;
		pos_first = {1'b0, count_q[5:2], 2'b00} + WORD_BYTES;
		pos_pad   = pos_q + WORD_BYTES;
		// move the gathered bytes to the top, marker right after them
		case (count_q[1:0])
			2'd0:    first_word = {PAD_MARK, 24'h0};
			2'd1:    first_word = {partial_q[7:0], PAD_MARK, 16'h0};
			2'd2:    first_word = {partial_q[15:0], PAD_MARK, 8'h0};
			2'd3:    first_word = {partial_q[23:0], PAD_MARK};
			default: first_word = '0;
		endcase
		status.word_done  = (count_inc[1:0] == 2'b00);
		status.first_last = (pos_first >= tgt_now);
		status.pad_last   = (pos_pad >= tgt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			partial_q <= '0;
		end else if (ctl.append) begin
			count_q   <= count_inc;
			partial_q <= status.word_done ? '0 : gathered;
		end else if (ctl.len_lo) begin
			count_q   <= '0;
			partial_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && status.word_done) begin
			word_q        <= gathered;
			block_end_q   <= (count_inc[5:0] == 6'd0);
			message_end_q <= 1'b0;
		end else if (ctl.first) begin
			word_q        <= first_word;
			block_end_q   <= (pos_first[5:0] == 6'd0);
			message_end_q <= 1'b0;
			pos_q         <= pos_first;
			hi_q          <= hi_now;
		end else if (ctl.zero) begin
			word_q        <= '0;
			block_end_q   <= (pos_pad[5:0] == 6'd0);
			message_end_q <= 1'b0;
			pos_q         <= pos_pad;
		end else if (ctl.len_hi) begin
			word_q        <= count_q[60:29];
			block_end_q   <= 1'b0;
			message_end_q <= 1'b0;
		end else if (ctl.len_lo) begin
			word_q        <= {count_q[28:0], 3'b000};
			block_end_q   <= 1'b1;
			message_end_q <= 1'b1;
		end
	end

	assign word        = word_q;
	assign block_end   = block_end_q;
	assign message_end = message_end_q;

endmodule

>>> rtl/core/sha_pad_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 padder controller
// Sequences append, padding and length words; owns both handshakes.
// ---------------------------------------------------------------------------
module sha_pad_ctrl import sha_pad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  pad_status_t status,
	output pad_cmd_t    ctl,
	output logic        out_valid,
	input  logic        out_stall
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PAD    = 2'd1;
	localparam logic [1:0] ST_LEN_HI = 2'd2;
	localparam logic [1:0] ST_LEN_LO = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       valid_q;
	logic       valid_d;
	logic       out_free;
	logic       in_acc;

	always_comb begin
		out_free = !valid_q || !out_stall;
		in_stall = !((state_q == ST_IDLE) && out_free);
		in_acc   = in_valid && !in_stall;
		ctl      = '0;
		state_d  = state_q;
		// drop the held word once taken
		valid_d  = valid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_APPEND) begin
						ctl.append = 1'b1;
						if (status.word_done) begin
							valid_d = 1'b1;
						end
					end else begin
						ctl.first = 1'b1;
						valid_d   = 1'b1;
						state_d   = status.first_last ? ST_LEN_HI : ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (out_free) begin
					ctl.zero = 1'b1;
					valid_d  = 1'b1;
					if (status.pad_last) begin
						state_d = ST_LEN_HI;
					end
				end
			end
			ST_LEN_HI: begin
				if (out_free) begin
					ctl.len_hi = 1'b1;
					valid_d    = 1'b1;
					state_d    = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				if (out_free) begin
					ctl.len_lo = 1'b1;
					valid_d    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

	assign out_valid = valid_q;

endmodule

>>> tb/sha256_message_padder_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 message padder testbench
// Sends append and finish transactions, predicts the padded word stream with
// its own model of the byte counter and partial word, and checks every word
// and its block/message end flags. A short table of directed transactions
// runs first, then random messages with random gaps and output stalls.
// ---------------------------------------------------------------------------
module sha256_message_padder_top_tb;
	import sha_pad_pkg::*;

	localparam int IDLE_LIMIT   = 400;
	localparam int RANDOM_ITEMS = 114;
	localparam int SETTLE       = 24;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              block_end;
		logic              message_end;
	} pad_word_t;

	// how a directed row is checked
	typedef enum {ROW_PREDICTED, ROW_QUIET, ROW_ONE_WORD, ROW_EMPTY_MSG} row_kind_t;

	typedef struct {
		logic              cmd;
		logic [7:0]        data;
		row_kind_t         kind;
		logic [WORD_W-1:0] word;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              cmd;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] word;
	logic              block_end;
	logic              message_end;

	// predictor state
	logic [COUNT_W-1:0] msg_bytes;
	logic [WORD_W-1:0]  gather_word;

	pad_word_t pending_words[$];
	dir_row_t  directed[$];

	int mismatches;
	int words_checked;
	int idle_cycles;
	int messages_sent;
	int bytes_sent;
	int longest_padding;
	int random_items;
	bit word_taken;
	bit rx_quiet;
	int rx_hold;

	sha256_message_padder_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word        (word),
		.block_end   (block_end),
		.message_end (message_end)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void push_word(ref pad_word_t q[$], input logic [WORD_W-1:0] w,
			input int pos, input logic last);
		pad_word_t item;
		item.word        = w;
		item.block_end   = (pos % 64 == 0);
		item.message_end = last;
		q.push_back(item);
	endfunction

	// Advance the padder state by one transaction and return the words it emits.
	function automatic void pad_predict(input logic c, input logic [7:0] d,
			ref pad_word_t q[$]);
		int                unsigned n;
		int                unsigned r;
		int                unsigned pos;
		int                unsigned target;
		logic [63:0]       bit_len;
		logic [WORD_W-1:0] w;
		if (c == CMD_APPEND) begin
			gather_word = {gather_word[23:0], d};
			msg_bytes   = msg_bytes + 1'b1;
			if (msg_bytes[1:0] == 2'd0) begin
				push_word(q, gather_word, int'(msg_bytes[5:0]), 1'b0);
				gather_word = '0;
			end
		end else begin
			n       = 32'(msg_bytes[5:0]);
			r       = n & 3;
			pos     = n - r;
			target  = (n < LEN_POS) ? 32'(LEN_POS) : 32'(LEN_POS_NEXT);
			bit_len = {msg_bytes, 3'b000};
			// move the gathered bytes to the top, marker right behind them
			w = (r == 0) ? '0 : gather_word << (8 * (4 - r));
			w = w | ({24'd0, PAD_MARK} << (8 * (3 - r)));
			pos += 4;
			push_word(q, w, pos, 1'b0);
			while (pos < target) begin
				pos += 4;
				push_word(q, '0, pos, 1'b0);
			end
			pos += 4;
			push_word(q, bit_len[63:32], pos, 1'b0);
			pos += 4;
			push_word(q, bit_len[31:0], pos, 1'b1);
			msg_bytes   = '0;
			gather_word = '0;
		end
	endfunction

	// Drive one transaction from a falling edge, hold it until accepted, then
	// predict it and leave the requested gap behind it.
	task automatic send_item(input logic c, input logic [7:0] d, input int gap,
			input bit use_model);
		pad_word_t produced[$];
		in_valid  = 1'b1;
		cmd       = c;
		data_byte = d;
		do @(posedge clk); while (in_stall);
		pad_predict(c, d, produced);
		if (use_model) begin
			foreach (produced[i]) pending_words.push_back(produced[i]);
		end
		if (c == CMD_FINISH) begin
			messages_sent++;
			if (produced.size() > longest_padding) longest_padding = produced.size();
		end else begin
			bytes_sent++;
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_words();
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
	endtask

	// Receiver: hold off for a random number of cycles after each word taken,
	// with occasional stretches of no stalls at all.
	always @(negedge clk) begin
		if (word_taken) begin
			if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
			rx_hold = rx_quiet ? 0 : $urandom_range(0, 9);
		end
		if (rx_hold > 0) begin
			out_stall = 1'b1;
			rx_hold--;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		pad_word_t exp_word;
		word_taken = out_valid && !out_stall;
		if ((in_valid && !in_stall) || word_taken) idle_cycles = 0;
		else idle_cycles++;
		if (word_taken) begin
			words_checked++;
			if (pending_words.size() == 0) begin
				$display("%0t: word %h arrived with nothing expected", $time, word);
				mismatches++;
			end else begin
				exp_word = pending_words.pop_front();
				if (word !== exp_word.word) begin
					$display("%0t: word expected %h actual %h", $time, exp_word.word, word);
					mismatches++;
				end
				if (block_end !== exp_word.block_end) begin
					$display("%0t: block_end expected %b actual %b", $time,
						exp_word.block_end, block_end);
					mismatches++;
				end
				if (message_end !== exp_word.message_end) begin
					$display("%0t: message_end expected %b actual %b", $time,
						exp_word.message_end, message_end);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("[sha256_message_padder_top] ERROR");
		$finish;
	end

	initial begin
		pad_word_t typed;
		int        msg_len;
		bit        burst;
		int        gap;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_APPEND;
		data_byte     = 8'h00;
		out_stall     = 1'b0;
		msg_bytes     = '0;
		gather_word   = '0;
		mismatches    = 0;
		words_checked = 0;
		idle_cycles   = 0;
		rx_hold       = 0;
		rx_quiet      = 1'b0;
		word_taken    = 1'b0;

		// empty message (data ignored), a full word of extreme bytes, then every
		// remainder of the last word, and two finishes back to back
		directed.push_back('{CMD_FINISH, 8'hFF, ROW_EMPTY_MSG, 32'h0});
		directed.push_back('{CMD_APPEND, 8'h00, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'hFF, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'h80, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'h7F, ROW_ONE_WORD,  32'h00FF807F});
		directed.push_back('{CMD_FINISH, 8'h00, ROW_PREDICTED, 32'h0});
		directed.push_back('{CMD_APPEND, 8'hA5, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_FINISH, 8'h5A, ROW_PREDICTED, 32'h0});
		directed.push_back('{CMD_APPEND, 8'h01, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'hFE, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_FINISH, 8'h00, ROW_PREDICTED, 32'h0});
		directed.push_back('{CMD_APPEND, 8'h12, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'h34, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_APPEND, 8'h56, ROW_QUIET,     32'h0});
		directed.push_back('{CMD_FINISH, 8'hFF, ROW_PREDICTED, 32'h0});
		directed.push_back('{CMD_FINISH, 8'h00, ROW_EMPTY_MSG, 32'h0});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			gap = $urandom_range(0, 9);
			send_item(directed[i].cmd, directed[i].data, 0,
				directed[i].kind == ROW_PREDICTED);
			// queue the typed words before the first of them can be taken
			case (directed[i].kind)
				ROW_ONE_WORD: begin
					typed = '{directed[i].word, 1'b0, 1'b0};
					pending_words.push_back(typed);
				end
				ROW_EMPTY_MSG: begin
					// marker word, fifteen zero words, last one closes block and message
					for (int k = 0; k < 16; k++) begin
						typed = '{(k == 0) ? 32'h8000_0000 : 32'h0, k == 15, k == 15};
						pending_words.push_back(typed);
					end
				end
				default: begin
				end
			endcase
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		// hold the sender until the directed words have all drained
		drain_words();
		@(negedge clk);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: msg_len = $urandom_range(0, 12);
				6, 7, 8:          msg_len = $urandom_range(50, 66);
				default:          msg_len = $urandom_range(0, 3);
			endcase
			// keep the last message inside the item budget
			if (msg_len > RANDOM_ITEMS - random_items - 1)
				msg_len = RANDOM_ITEMS - random_items - 1;
			burst = ($urandom_range(0, 3) == 0);
			for (int b = 0; b <= msg_len; b++) begin
				gap = burst ? 0 : $urandom_range(0, 9);
				if (b < msg_len) send_item(CMD_APPEND, 8'($urandom_range(0, 255)), gap, 1'b1);
				else send_item(CMD_FINISH, 8'($urandom_range(0, 255)), gap, 1'b1);
				random_items++;
			end
			if ($urandom_range(0, 4) == 0) drain_words();
		end

		drain_words();
		repeat (SETTLE) @(negedge clk);
		if (pending_words.size() != 0) begin
			$display("%0t: %0d words never arrived", $time, pending_words.size());
			mismatches++;
		end

		$display("Padded %0d messages from %0d bytes; %0d words checked,",
			messages_sent, bytes_sent, words_checked);
		$display("longest padding %0d words", longest_padding);
		if (mismatches == 0) begin
			$display("[sha256_message_padder_top] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[sha256_message_padder_top] ERROR");
		end
		$finish;
	end

endmodule
